/* design/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRACTION_BITS_DEFAULT = 8;
    localparam int DATA_W = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [3:0] {
        ACT_ADD     = 4'd0,
        ACT_SUB     = 4'd1,
        ACT_MUL     = 4'd2,
        ACT_DIV     = 4'd3,
        ACT_GT      = 4'd4,
        ACT_LT      = 4'd5,
        ACT_EQ      = 4'd6,
        ACT_NE      = 4'd7,
        ACT_LE      = 4'd8,
        ACT_GE      = 4'd9,
        ACT_MIN     = 4'd10,
        ACT_MAX     = 4'd11,
        ACT_INC     = 4'd12,
        ACT_DEC     = 4'd13,
        ACT_TOINT   = 4'd14,
        ACT_FROMINT = 4'd15
    } action_t;

    // Classified operation handed from front to back.
    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0,
        CLS_MUL    = 2'd1,
        CLS_DIV    = 2'd2
    } op_class_t;

    typedef struct packed {
        op_class_t         cls;
        logic              neg;
        logic              div_zero;
        logic [31:0]       mag_a;
        logic [31:0]       mag_b;
        logic signed [31:0] simple_value;
        logic              simple_cmp;
        logic              simple_sat;
    } fpa_op_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic              cmp;
        logic              dz;
        logic              sat;
    } fpa_res_t;

endpackage

/* design/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed 32-bit fixed-point ALU (Q(32-F).F) with a streaming interface.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per transaction: action, operand_a and
//   operand_b. m_axis returns exactly one result per operation, in order.
//   The front decodes and finishes simple actions (add, sub, compares,
//   min/max, inc/dec, toint, fromint) and computes operand magnitudes; a
//   four-entry queue separates it from the back end.
//   The back end is a fixed pipeline of 32+FRACTION_BITS divider stages
//   (one quotient bit each) with the multiplier product carried alongside,
//   plus an output register. Every action walks the same pipeline, which
//   accepts one transaction per cycle while the receiver does not stall.
//   Reset (rst_n low, asynchronous) empties the queue and pipeline.
//   When the receiver stalls the whole back pipeline holds; the queue then
//   absorbs up to four more transactions before s_axis_tready drops.
// ----------------------------------------------------------------------------
module fixed_point_alu
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // action[3:0], operand_a[35:4], operand_b[67:36]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // result_value[31:0], compare_true[32],
                                       // divide_by_zero[33], saturated[34]
);

    fpa_op_t  dec_op, q_op;
    fpa_res_t res;
    logic     q_full, q_empty, back_ready, back_valid;

    fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .action    (s_axis_tdata[3:0]),
        .operand_a (s_axis_tdata[35:4]),
        .operand_b (s_axis_tdata[67:36]),
        .op        (dec_op)
    );

    assign s_axis_tready = !q_full;

    fpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_data (dec_op),
        .full      (q_full),
        .pop       (back_ready),
        .pop_data  (q_op),
        .empty     (q_empty)
    );

    fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!q_empty),
        .in_op     (q_op),
        .in_ready  (back_ready),
        .out_valid (back_valid),
        .out_res   (res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tvalid = back_valid;
    assign m_axis_tdata = {5'd0, res.sat, res.dz, res.cmp, res.value};

endmodule

/* design/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front
// Decodes an action, finishes simple ones, prepares magnitudes for mul/div.
// ----------------------------------------------------------------------------
module fpa_front
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic [3:0]         action,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output fpa_op_t            op
);

    localparam logic signed [33:0] MAX32 = 34'sd2147483647;
    localparam logic signed [33:0] MIN32 = -34'sd2147483648;

    logic signed [33:0] sum;
    logic signed [63:0] shl;
    logic               lt;

    always_comb
    begin
        op = '0;
        sum = '0;
        lt = operand_a < operand_b;
        shl = 64'(operand_a) <<< FRACTION_BITS;
        op.mag_a = operand_a[31] ? 32'(-operand_a) : operand_a;
        op.mag_b = operand_b[31] ? 32'(-operand_b) : operand_b;
        op.neg = operand_a[31] ^ operand_b[31];
        op.cls = CLS_SIMPLE;
        case (action_t'(action))
            ACT_ADD: sum = 34'(operand_a) + 34'(operand_b);
            ACT_SUB: sum = 34'(operand_a) - 34'(operand_b);
            ACT_INC: sum = 34'(operand_a) + 34'sd1;
            ACT_DEC: sum = 34'(operand_a) - 34'sd1;
            ACT_MUL: op.cls = CLS_MUL;
            ACT_DIV:
            begin
                op.cls = CLS_DIV;
                op.div_zero = (operand_b == 32'sd0);
            end
            ACT_GT: op.simple_cmp = !lt && operand_a != operand_b;
            ACT_LT: op.simple_cmp = lt;
            ACT_EQ: op.simple_cmp = operand_a == operand_b;
            ACT_NE: op.simple_cmp = operand_a != operand_b;
            ACT_LE: op.simple_cmp = lt || operand_a == operand_b;
            ACT_GE: op.simple_cmp = !lt;
            ACT_MIN: op.simple_value = lt ? operand_a : operand_b;
            ACT_MAX: op.simple_value = lt ? operand_b : operand_a;
            ACT_TOINT: op.simple_value = operand_a >>> FRACTION_BITS;
            ACT_FROMINT:
            begin
                if (shl > 64'(MAX32))
                begin
                    op.simple_value = 32'sh7fffffff;
                    op.simple_sat = 1'b1;
                end
                else if (shl < 64'(MIN32))
                begin
                    op.simple_value = 32'sh80000000;
                    op.simple_sat = 1'b1;
                end
                else
                    op.simple_value = shl[31:0];
            end
            default: op.simple_value = '0;
        endcase
        if (action_t'(action) == ACT_ADD || action_t'(action) == ACT_SUB ||
            action_t'(action) == ACT_INC || action_t'(action) == ACT_DEC)
        begin
            if (sum > MAX32)
            begin
                op.simple_value = 32'sh7fffffff;
                op.simple_sat = 1'b1;
            end
            else if (sum < MIN32)
            begin
                op.simple_value = 32'sh80000000;
                op.simple_sat = 1'b1;
            end
            else
                op.simple_value = sum[31:0];
        end
    end

endmodule

/* design/fpa_queue.sv */
// ----------------------------------------------------------------------------
// fpa_queue
// Small FIFO decoupling the front decode from the back execution.
// ----------------------------------------------------------------------------
module fpa_queue
    import fpa_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  fpa_op_t push_data,
    output logic    full,
    input  logic    pop,
    output fpa_op_t pop_data,
    output logic    empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    fpa_op_t          mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign full = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(full && empty))
        else $error("queue full and empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && !(pop && !empty)) |=> !empty)
        else $error("push lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count overflow");

endmodule

/* design/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: multiplier and a pipelined restoring divider.
// ----------------------------------------------------------------------------
module fpa_back
    import fpa_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  fpa_op_t  in_op,
    output logic     in_ready,
    output logic     out_valid,
    output fpa_res_t out_res,
    input  logic     out_ready
);

    // Quotient magnitude bits: (2*|a|*2^F + |b|) / (2*|b|) < 2^(32+F).
    localparam int QW  = 32 + FRACTION_BITS;
    localparam int NW  = QW + 2;          // numerator width
    localparam int NST = QW;              // one quotient bit per stage
    localparam int PW  = 64;

    typedef struct packed {
        op_class_t          cls;
        logic               neg;
        logic               div_zero;
        logic [32:0]        den;          // 2*|b|
        logic [NW-1:0]      num;          // full numerator; stage s takes bit QW-1-s
        logic [NW-1:0]      rem;
        logic [QW-1:0]      quo;
        logic [PW-1:0]      prod;
        logic signed [31:0] simple_value;
        logic               simple_cmp;
        logic               simple_sat;
    } stage_t;

    stage_t st_reg [NST+1];
    logic   v_reg  [NST+1];
    logic   advance;

    fpa_res_t res_next, res_reg;
    logic     res_v_reg;
    logic [PW-1:0] mag_res;
    logic [PW:0]   rnd;
    logic [NW-1:0] num_init;

    // Pipeline moves when the output register is free or being drained.
    assign advance = !res_v_reg || out_ready;
    assign in_ready = advance;

    assign num_init = (NW'(in_op.mag_a) << (FRACTION_BITS + 1)) + NW'(in_op.mag_b);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0].cls <= in_op.cls;
            st_reg[0].neg <= in_op.neg;
            st_reg[0].div_zero <= in_op.div_zero;
            st_reg[0].den <= {in_op.mag_b, 1'b0};
            st_reg[0].num <= num_init;
            // bits above the stage range seed the remainder; den >= 2 keeps
            // their quotient bits zero
            st_reg[0].rem <= NW'(num_init[NW-1:QW]);
            st_reg[0].quo <= '0;
            st_reg[0].prod <= PW'(in_op.mag_a) * PW'(in_op.mag_b);
            st_reg[0].simple_value <= in_op.simple_value;
            st_reg[0].simple_cmp <= in_op.simple_cmp;
            st_reg[0].simple_sat <= in_op.simple_sat;
        end
    end

    for (genvar s = 0; s < NST; s++)
    begin : g_div
        logic [NW-1:0] r_sh;
        logic          ge;
        stage_t        st_next;
        always_comb
        begin
            r_sh = {st_reg[s].rem[NW-2:0], st_reg[s].num[QW-1-s]};
            ge = r_sh >= NW'(st_reg[s].den);
            st_next = st_reg[s];
            st_next.rem = ge ? r_sh - NW'(st_reg[s].den) : r_sh;
            st_next.quo = {st_reg[s].quo[QW-2:0], ge};
        end
        always_ff @(posedge clk)
        begin
            if (advance)
                st_reg[s+1] <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NST; i++)
                v_reg[i] <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= NST; i++)
                v_reg[i] <= v_reg[i-1];
            res_v_reg <= v_reg[NST];
        end
    end

    always_comb
    begin
        res_next = '0;
        rnd = (PW+1)'(st_reg[NST].prod) + (PW+1)'((64'd1 << FRACTION_BITS) >> 1);
        mag_res = (st_reg[NST].cls == CLS_MUL) ? PW'(rnd >> FRACTION_BITS)
                                               : PW'(st_reg[NST].quo);
        case (st_reg[NST].cls)
            CLS_MUL, CLS_DIV:
            begin
                if (st_reg[NST].cls == CLS_DIV && st_reg[NST].div_zero)
                    res_next.dz = 1'b1;
                else if (!st_reg[NST].neg && mag_res > 64'h7fffffff)
                begin
                    res_next.value = 32'sh7fffffff;
                    res_next.sat = 1'b1;
                end
                else if (st_reg[NST].neg && mag_res > 64'h80000000)
                begin
                    res_next.value = 32'sh80000000;
                    res_next.sat = 1'b1;
                end
                else
                    res_next.value = st_reg[NST].neg ? -mag_res[31:0] : mag_res[31:0];
            end
            default:
            begin
                res_next.value = st_reg[NST].simple_value;
                res_next.cmp = st_reg[NST].simple_cmp;
                res_next.sat = st_reg[NST].simple_sat;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = res_v_reg;
    assign out_res = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_res.dz && out_res.sat))
        else $error("divide by zero also saturated");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_res.dz) |-> out_res.value == 32'sd0)
        else $error("divide by zero nonzero result");

endmodule
